### src/rfidfc_pkg.sv
package rfidfc_pkg;

	localparam logic [7:0] STX_BYTE = 8'd2;
	localparam logic [7:0] ETX_BYTE = 8'd3;
	localparam logic [7:0] CR_BYTE  = 8'd13;
	localparam logic [7:0] LF_BYTE  = 8'd10;
	localparam logic [7:0] NOT_HEX  = 8'hFF;

	localparam int STORE_LEN = 12;

	// Frame positions: bytes of the current frame taken so far.
	localparam logic [4:0] POS_HUNT      = 5'd0;
	localparam logic [4:0] POS_TAG_FIRST = 5'd1;
	localparam logic [4:0] POS_TAG_LAST  = 5'd10;
	localparam logic [4:0] POS_SUM_FIRST = 5'd11;
	localparam logic [4:0] POS_SUM_LAST  = 5'd12;
	localparam logic [4:0] POS_CR        = 5'd13;
	localparam logic [4:0] POS_LF        = 5'd14;
	localparam logic [4:0] POS_ETX       = 5'd15;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FRAME = 2'd1,
		STATUS_SUM   = 2'd2
	} status_t;

	typedef struct packed {
		logic [39:0] tag_first_chars;
		logic [39:0] tag_last_chars;
		logic [15:0] check_chars;
		status_t     status;
	} result_t;

	function automatic logic [7:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		if (c inside {[8'h30:8'h39]}) begin
			v = c & 8'h0F;
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			v = (c & 8'h0F) + 8'd9;
		end else begin
			v = NOT_HEX;
		end
		return v;
	endfunction

endpackage

### src/rfidfc_frame_core.sv
module rfidfc_frame_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	input  logic               in_range,
	output logic               done,
	output rfidfc_pkg::result_t result
);
	import rfidfc_pkg::*;

	logic [4:0] pos_q, pos_d;
	logic [7:0] even_xor_q, even_xor_d;
	logic [7:0] odd_xor_q, odd_xor_d;
	logic       trailer_error_q, trailer_error_d;
	logic [7:0] store_q [STORE_LEN];
	logic       store_we;
	logic [4:0] pos_m1;
	logic [3:0] store_idx;
	logic [7:0] digit;
	logic       frame_bad;
	logic       sum_bad;

	assign pos_m1    = pos_q - 5'd1;
	assign store_idx = pos_m1[3:0];
	assign digit     = hex_value(rx_byte);

	always_comb begin
		pos_d           = pos_q;
		even_xor_d      = even_xor_q;
		odd_xor_d       = odd_xor_q;
		trailer_error_d = trailer_error_q;
		store_we        = 1'b0;
		done            = 1'b0;
		if (step) begin
			if (!in_range) begin
				pos_d           = POS_HUNT;
				even_xor_d      = '0;
				odd_xor_d       = '0;
				trailer_error_d = 1'b0;
			end else if (pos_q inside {[POS_TAG_FIRST:POS_TAG_LAST]}) begin
				store_we = 1'b1;
				// Odd positions hold even-indexed tag characters.
				if (pos_q[0]) begin
					even_xor_d = even_xor_q ^ digit;
				end else begin
					odd_xor_d = odd_xor_q ^ digit;
				end
				pos_d = pos_q + 5'd1;
			end else if (pos_q inside {POS_SUM_FIRST, POS_SUM_LAST}) begin
				store_we = 1'b1;
				pos_d    = pos_q + 5'd1;
			end else if (pos_q == POS_CR) begin
				if (rx_byte != CR_BYTE) begin
					trailer_error_d = 1'b1;
				end
				pos_d = POS_LF;
			end else if (pos_q == POS_LF) begin
				if (rx_byte != LF_BYTE) begin
					trailer_error_d = 1'b1;
				end
				pos_d = POS_ETX;
			end else if (pos_q == POS_ETX) begin
				done            = 1'b1;
				pos_d           = POS_HUNT;
				even_xor_d      = '0;
				odd_xor_d       = '0;
				trailer_error_d = 1'b0;
			end else begin
				// Hunting: anything but the start byte is dropped.
				pos_d           = (rx_byte == STX_BYTE) ? POS_TAG_FIRST : POS_HUNT;
				even_xor_d      = '0;
				odd_xor_d       = '0;
				trailer_error_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q           <= POS_HUNT;
			even_xor_q      <= '0;
			odd_xor_q       <= '0;
			trailer_error_q <= 1'b0;
		end else begin
			pos_q           <= pos_d;
			even_xor_q      <= even_xor_d;
			odd_xor_q       <= odd_xor_d;
			trailer_error_q <= trailer_error_d;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[store_idx] <= rx_byte;
		end
	end

	assign frame_bad = trailer_error_q || (rx_byte != ETX_BYTE);
	assign sum_bad   = (even_xor_q != hex_value(store_q[10])) ||
	                   (odd_xor_q != hex_value(store_q[11]));

	always_comb begin
		result.tag_first_chars = {store_q[0], store_q[1], store_q[2], store_q[3], store_q[4]};
		result.tag_last_chars  = {store_q[5], store_q[6], store_q[7], store_q[8], store_q[9]};
		result.check_chars     = {store_q[10], store_q[11]};
		if (frame_bad) begin
			result.status = STATUS_FRAME;
		end else if (sum_bad) begin
			result.status = STATUS_SUM;
		end else begin
			result.status = STATUS_OK;
		end
	end

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_ETX)
		else $error("frame position out of range");

	a_out_of_range_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !in_range) |=> (pos_q == POS_HUNT && even_xor_q == 8'd0 &&
		odd_xor_q == 8'd0 && !trailer_error_q))
		else $error("tag out of range did not restart the frame");

	a_done_returns_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (pos_q == POS_HUNT && !trailer_error_q))
		else $error("frame end did not return to hunting");
`endif

endmodule

### src/rfid_ascii_frame_checker_top.sv
// Checks reader frames of STX, ten ASCII-hex tag characters, two checksum
// characters, CR, LF and ETX, one serial byte per request. A byte is taken
// every clock cycle while in_stall is low; an accepted ETX byte goes through the
// input register, and its result is then caught in the result register. A result
// appears only for a completed sixteen-byte frame, with status 0 valid,
// 1 framing error on CR, LF or ETX (which wins over a checksum error) and
// 2 checksum mismatch. A low in_range drops the partial frame. in_stall
// follows out_stall in the same cycle while a result is held and a byte waits.
module rfid_ascii_frame_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        in_range,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [39:0] tag_first_chars,
	output logic [39:0] tag_last_chars,
	output logic [15:0] check_chars,
	output logic [1:0]  status
);
	import rfidfc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       range_s1;
	logic       advance;
	logic       done;
	result_t    result;
	logic       out_valid_q;
	result_t    result_q;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= rx_byte;
			range_s1 <= in_range;
		end
	end

	rfidfc_frame_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (valid_s1 && advance),
		.rx_byte  (byte_s1),
		.in_range (range_s1),
		.done     (done),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (done && advance) begin
			result_q <= result;
		end
	end

	assign out_valid       = out_valid_q;
	assign tag_first_chars = result_q.tag_first_chars;
	assign tag_last_chars  = result_q.tag_last_chars;
	assign check_chars     = result_q.check_chars;
	assign status          = result_q.status;

`ifndef ASSERT_OFF
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled without a waiting request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.status == STATUS_OK || result_q.status == STATUS_FRAME ||
		result_q.status == STATUS_SUM))
		else $error("result carries an unknown status");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(result_q)))
		else $error("stalled result changed");
`endif

endmodule

### tb/sv/tb_rfid_ascii_frame_checker_top.sv
`timescale 1ns / 100ps

module tb_rfid_ascii_frame_checker_top;
	import rfidfc_pkg::*;

	localparam int IDLE_LIMIT  = 3000;
	localparam int FRAME_ITEMS = 1250;
	localparam int LONG_HOLD   = 300;

	typedef struct {
		logic [7:0] rx;
		logic       present;
	} serial_byte_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HALF,
		STALL_HEAVY
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        in_range = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [39:0] tag_first_chars;
	logic [39:0] tag_last_chars;
	logic [15:0] check_chars;
	logic [1:0]  status;

	rfid_ascii_frame_checker_top uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.in_range        (in_range),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.tag_first_chars (tag_first_chars),
		.tag_last_chars  (tag_last_chars),
		.check_chars     (check_chars),
		.status          (status)
	);

	always #10 clk = ~clk;

	// Stimulus and expected results.
	serial_byte_t pending_bytes[$];
	result_t      expected_frames[$];
	logic [7:0]   frame_buf [16];
	int           frame_items = 0;
	int           mismatch_count = 0;
	int           results_seen = 0;

	// Shadow state of the frame checker.
	logic [4:0]   shadow_pos = POS_HUNT;
	logic [7:0]   shadow_chars [STORE_LEN];
	logic [7:0]   shadow_even = 8'd0;
	logic [7:0]   shadow_odd = 8'd0;
	logic         shadow_trailer_bad = 1'b0;

	function automatic logic [7:0] decode_hex(input logic [7:0] c);
		logic [7:0] v;
		v = NOT_HEX;
		if (c >= "0" && c <= "9")
			v = c - "0";
		else if (c >= "A" && c <= "F")
			v = c - "A" + 8'd10;
		else if (c >= "a" && c <= "f")
			v = c - "a" + 8'd10;
		return v;
	endfunction

	// Picks an ASCII character that decodes to v, in either case for letters.
	function automatic logic [7:0] encode_hex(input logic [7:0] v);
		logic [7:0] c;
		if (v <= 8'd9) begin
			c = "0" + v;
		end else if (v <= 8'd15) begin
			c = ($urandom_range(0, 1) != 0) ? "A" + v - 8'd10 : "a" + v - 8'd10;
		end else begin
			// Values 16..254 have no character and, like 255, get any non-hex byte.
			c = 8'($urandom_range(0, 255));
			while (decode_hex(c) != NOT_HEX)
				c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	function automatic logic [7:0] random_tag_char(input int hex_pct);
		logic [7:0] c;
		if ($urandom_range(0, 99) < hex_pct)
			c = encode_hex(8'($urandom_range(0, 15)));
		else
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic present, input bit counted);
		serial_byte_t item;
		item.rx = b;
		item.present = present;
		pending_bytes.push_back(item);
		if (counted)
			frame_items++;
	endtask

	// Completes frame_buf around its ten tag characters and queues all sixteen bytes.
	task automatic queue_frame(input bit good_sum, input bit good_trailer);
		logic [7:0] even_acc;
		logic [7:0] odd_acc;
		int         bad_at;
		even_acc = 8'd0;
		odd_acc = 8'd0;
		frame_buf[0] = STX_BYTE;
		for (int k = 0; k < 10; k++) begin
			if (k % 2 == 0)
				even_acc ^= decode_hex(frame_buf[1 + k]);
			else
				odd_acc ^= decode_hex(frame_buf[1 + k]);
		end
		if (good_sum) begin
			frame_buf[11] = encode_hex(even_acc);
			frame_buf[12] = encode_hex(odd_acc);
		end else begin
			frame_buf[11] = ($urandom_range(0, 1) != 0) ? random_tag_char(80) : encode_hex(even_acc);
			frame_buf[12] = random_tag_char(80);
		end
		frame_buf[13] = CR_BYTE;
		frame_buf[14] = LF_BYTE;
		frame_buf[15] = ETX_BYTE;
		if (!good_trailer) begin
			bad_at = $urandom_range(13, 15);
			frame_buf[bad_at] = 8'($urandom_range(0, 255));
		end
		for (int i = 0; i < 16; i++)
			queue_byte(frame_buf[i], 1'b1, 1'b1);
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic present);
		result_t res;
		logic    sum_bad;
		if (!present || shadow_pos == POS_HUNT) begin
			shadow_pos = (present && b == STX_BYTE) ? POS_TAG_FIRST : POS_HUNT;
			shadow_even = 8'd0;
			shadow_odd = 8'd0;
			shadow_trailer_bad = 1'b0;
		end else if (shadow_pos <= POS_TAG_LAST) begin
			shadow_chars[4'(shadow_pos - 5'd1)] = b;
			// Tag positions count from zero, so the first character is even.
			if (shadow_pos[0])
				shadow_even ^= decode_hex(b);
			else
				shadow_odd ^= decode_hex(b);
			shadow_pos++;
		end else if (shadow_pos <= POS_SUM_LAST) begin
			shadow_chars[4'(shadow_pos - 5'd1)] = b;
			shadow_pos++;
		end else if (shadow_pos == POS_CR) begin
			if (b != CR_BYTE)
				shadow_trailer_bad = 1'b1;
			shadow_pos = POS_LF;
		end else if (shadow_pos == POS_LF) begin
			if (b != LF_BYTE)
				shadow_trailer_bad = 1'b1;
			shadow_pos = POS_ETX;
		end else begin
			sum_bad = (shadow_even != decode_hex(shadow_chars[10])) ||
				(shadow_odd != decode_hex(shadow_chars[11]));
			res.tag_first_chars = {shadow_chars[0], shadow_chars[1], shadow_chars[2],
				shadow_chars[3], shadow_chars[4]};
			res.tag_last_chars = {shadow_chars[5], shadow_chars[6], shadow_chars[7],
				shadow_chars[8], shadow_chars[9]};
			res.check_chars = {shadow_chars[10], shadow_chars[11]};
			if (shadow_trailer_bad || b != ETX_BYTE)
				res.status = STATUS_FRAME;
			else if (sum_bad)
				res.status = STATUS_SUM;
			else
				res.status = STATUS_OK;
			expected_frames.push_back(res);
			shadow_pos = POS_HUNT;
			shadow_even = 8'd0;
			shadow_odd = 8'd0;
			shadow_trailer_bad = 1'b0;
		end
	endtask

	initial begin
		string directed_tag;
		int    pick;
		int    keep;
		directed_tag = "09AFaf19Bc";

		// Noise while hunting, and a start byte with the tag out of range.
		queue_byte(8'h00, 1'b1, 1'b0);
		queue_byte(8'hFF, 1'b1, 1'b0);
		queue_byte(ETX_BYTE, 1'b1, 1'b0);
		queue_byte(STX_BYTE, 1'b0, 1'b0);
		for (int i = 0; i < 10; i++)
			frame_buf[1 + i] = directed_tag[i];
		queue_frame(1'b1, 1'b1);
		// A partial frame dropped when the tag leaves range.
		queue_byte(STX_BYTE, 1'b1, 1'b1);
		queue_byte("7", 1'b1, 1'b1);
		queue_byte("e", 1'b1, 1'b1);
		queue_byte("D", 1'b1, 1'b1);
		queue_byte(8'h80, 1'b0, 1'b1);

		while (frame_items < FRAME_ITEMS) begin
			pick = $urandom_range(0, 99);
			for (int i = 1; i <= 10; i++)
				frame_buf[i] = random_tag_char(90);
			if (pick < 60) begin
				queue_frame($urandom_range(0, 3) != 0, $urandom_range(0, 6) != 0);
			end else if (pick < 75) begin
				keep = $urandom_range(1, 15);
				queue_frame(1'b1, 1'b1);
				for (int i = 0; i < 16 - keep; i++)
					void'(pending_bytes.pop_back());
				frame_items -= 16 - keep;
				queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 5))
					queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
			end else begin
				// Arbitrary bytes in the tag and in the CR place, with a checksum not forced to match.
				for (int i = 1; i <= 10; i++)
					frame_buf[i] = 8'($urandom_range(0, 255));
				queue_frame(1'b0, 1'b1);
				frame_buf[13] = 8'($urandom_range(0, 255));
				pending_bytes[pending_bytes.size() - 3].rx = frame_buf[13];
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Sender: bursts of random length separated by random gaps.
	int           burst_left = 0;
	int           gap_left = 0;
	serial_byte_t next_byte;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'd0;
			in_range <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predict_byte(rx_byte, in_range);
			if (in_valid && in_stall) begin
				// A stalled request holds its payload.
			end else if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				next_byte = pending_bytes.pop_front();
				rx_byte <= next_byte.rx;
				in_range <= next_byte.present;
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall density changes from phase to phase, with one long hold
	// that lets the block back up into its input.
	stall_mode_t stall_mode = STALL_NONE;
	int          phase_left = 0;
	int          hold_left = 0;
	bit          long_hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!long_hold_done && results_seen >= 20) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			if (phase_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				phase_left = $urandom_range(16, 128);
			end else begin
				phase_left--;
			end
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
				default:     out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	result_t frame_want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected result, actual tag %h %h check %h status %0d",
					$time, tag_first_chars, tag_last_chars, check_chars, status);
				mismatch_count++;
			end else begin
				frame_want = expected_frames.pop_front();
				if (tag_first_chars !== frame_want.tag_first_chars) begin
					$display("%0t: tag_first_chars expected %h actual %h",
						$time, frame_want.tag_first_chars, tag_first_chars);
					mismatch_count++;
				end
				if (tag_last_chars !== frame_want.tag_last_chars) begin
					$display("%0t: tag_last_chars expected %h actual %h",
						$time, frame_want.tag_last_chars, tag_last_chars);
					mismatch_count++;
				end
				if (check_chars !== frame_want.check_chars) begin
					$display("%0t: check_chars expected %h actual %h",
						$time, frame_want.check_chars, check_chars);
					mismatch_count++;
				end
				if (status !== frame_want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, frame_want.status, status);
					mismatch_count++;
				end
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("%0t: no request moved for %0d cycles", $time, idle_cycles);
					$display("end of test: mismatches");
					$finish;
				end
			end
		end
	end

endmodule
